@@ sv/pdr_pkg.sv @@
package pdr_pkg;

  typedef enum logic [2:0] {
    OP_SET   = 3'd0,
    OP_STOP  = 3'd1,
    OP_ALL   = 3'd2,
    OP_TICK  = 3'd3,
    OP_EN    = 3'd4,
    OP_DIS   = 3'd5
  } op_t;

  localparam logic [2:0] CFG_MIN   = 3'd0;
  localparam logic [2:0] CFG_MAX   = 3'd1;
  localparam logic [2:0] CFG_UP    = 3'd2;
  localparam logic [2:0] CFG_DOWN  = 3'd3;
  localparam logic [2:0] CFG_EN    = 3'd4;
  localparam logic [2:0] CFG_REV   = 3'd5;
  localparam logic [2:0] CFG_ALT   = 3'd6;

  localparam int PCT_BITS = 7;
  localparam int Q_BITS   = 17;              // Q0.16 duty with one headroom bit
  localparam logic [16:0] DUTY_ONE = 17'h10000;
  // divide by 25 (102400 / 65536 reduced) as ceil(2^26 / 25), exact below 2^21
  localparam logic [21:0] PCT_RECIP = 22'd2684355;
  localparam int          PCT_SHIFT = 26;
  localparam logic [47:0] MAX_RESET = 48'd211366500;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISP,
    ST_SI_MUL,
    ST_SI_DIV,
    ST_SI_FIN,
    ST_TK_CHK,
    ST_TK_MUL,
    ST_TK_DIV,
    ST_TK_EMIT,
    ST_BANK
  } state_t;

endpackage

@@ sv/pdr_if.sv @@
interface pdr_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic [1:0]  channel;
  logic [10:0] intensity;
  logic [31:0] now_ms;
  modport source (output valid, operation, channel, intensity, now_ms, input ready);
  modport sink   (input valid, operation, channel, intensity, now_ms, output ready);
endinterface

interface pdr_out_if #(parameter int DUTY_BITS = 10);
  logic                 valid;
  logic                 ready;
  logic [1:0]           out_channel;
  logic [DUTY_BITS-1:0] duty_code;
  logic                 duty_written;
  logic                 direction;
  logic                 direction_written;
  logic                 last;
  modport source (output valid, out_channel, duty_code, duty_written, direction,
                  direction_written, last, input ready);
  modport sink   (input valid, out_channel, duty_code, duty_written, direction,
                  direction_written, last, output ready);
endinterface

interface pdr_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [47:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ sv/pdr_div.sv @@
// Restoring divider, one quotient bit per cycle.
module pdr_div #(
  parameter int NW = 29,
  parameter int DW = 12
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [NW-1:0] quot
);
  localparam int CNTW = $clog2(NW + 1);

  logic [DW-1:0]   rem_r, d_r;
  logic [NW-1:0]   q_r;
  logic [CNTW-1:0] cnt_r;
  logic            busy_r, done_r;
  logic [DW:0]     trial;
  logic            fits;

  assign trial = {rem_r, q_r[NW-1]};
  assign fits  = trial >= {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNTW'(NW);
        rem_r  <= '0;
        q_r    <= dividend;
        d_r    <= divisor;
      end else if (busy_r) begin
        rem_r <= fits ? DW'(trial - {1'b0, d_r}) : trial[DW-1:0];
        q_r   <= {q_r[NW-2:0], fits};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNTW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = q_r;
endmodule

@@ sv/multi_channel_pwm_duty_ramper_unit.sv @@
// channel  dir  handshake    payload
// in_ch    in   valid/ready  operation, channel, intensity, now_ms
// out_ch   out  valid/ready  out_channel, duty_code, duty_written, direction,
//                            direction_written, last
// cfg_ch   in   valid/ready  index, data (always ready)
//
// One word at a time: in_ch is ready only while the sequencer is idle.
// Every command passes through accept and dispatch. A nonzero set intensity
// on an enabled channel adds window products, multiply by the reciprocal of
// 25 and ramp write. Tick skips a settled channel, emits one at ramp end
// directly, and otherwise multiplies, divides serially by the ramp length
// and emits. Bank-wide ops visit each channel in turn; others end at dispatch.
// Reset is synchronous, active low, and clears all channel state at once.
// A stalled out_ch holds the sequencer at the emitting step; one result
// sits in the output register so the last word does not block in_ch.
module multi_channel_pwm_duty_ramper_unit #(
  parameter int NUM_CHANNELS = 4,
  parameter int DUTY_BITS    = 10,
  parameter int RAMP_BITS    = 12
) (
  input  logic clk,
  input  logic rst_n,
  pdr_in_if.sink            in_ch,
  pdr_out_if.source         out_ch,
  pdr_cfg_if.sink           cfg_ch
);
  localparam int N   = NUM_CHANNELS;
  localparam int CW  = (N > 1) ? $clog2(N) : 1;
  localparam int RB  = RAMP_BITS;
  localparam int QB  = pdr_pkg::Q_BITS;
  localparam int NW  = QB + RB;           // interpolation product width
  localparam int PB  = pdr_pkg::PCT_BITS;
  localparam int CDW = QB + DUTY_BITS + 1;
  localparam logic [DUTY_BITS-1:0] MAXC = {DUTY_BITS{1'b1}};

  // config registers
  logic [27:0] min_r, max_r;
  logic [47:0] up_r, dn_r;
  logic [3:0]  en_r, rev_r, alt_r;

  // channel state
  logic [QB-1:0] cur_r [N];
  logic [QB-1:0] st_r  [N];
  logic [QB-1:0] goal_r[N];
  logic [31:0]   beg_r [N];
  logic [RB-1:0] len_r [N];
  logic [N-1:0]  snd_r, par_r, dir_r;
  logic          bank_on_r;

  // captured command
  logic [2:0]  op_r;
  logic [1:0]  ch_r;
  logic [10:0] int_r;
  logic [31:0] now_r;

  pdr_pkg::state_t state_r, state_nxt;
  logic [CW-1:0] c_r;
  logic [N-1:0]  em_r;      // channels that will emit on this tick
  logic [QB-1:0] tgt_r;
  logic [NW-1:0] prod_r;

  // output register
  logic                 o_valid_r;
  logic [1:0]           o_ch_r;
  logic [DUTY_BITS-1:0] o_code_r;
  logic                 o_dw_r, o_dir_r, o_dirw_r, o_last_r;
  logic                 out_free;
  logic                 emit;

  function automatic logic bit_of(input logic [3:0] m, input int c);
    bit_of = (c < 4) ? m[c[1:0]] : 1'b0;
  endfunction

  function automatic logic [PB-1:0] pct_of(input logic [27:0] r, input int c);
    pct_of = PB'(r >> (c * PB));
  endfunction

  function automatic logic [RB-1:0] ramp_of(input logic [47:0] r, input int c);
    ramp_of = RB'(r >> (c * RB));
  endfunction

  // channel select: addressed channel for commands, sweep counter otherwise
  logic          sweep;
  logic [CW-1:0] idx;
  logic          ch_ok;
  logic [QB-1:0] cur, st, goal;
  logic [RB-1:0] len;
  logic          snd;

  assign sweep = (state_r == pdr_pkg::ST_TK_CHK) || (state_r == pdr_pkg::ST_TK_MUL) ||
                 (state_r == pdr_pkg::ST_TK_DIV) || (state_r == pdr_pkg::ST_TK_EMIT) ||
                 (state_r == pdr_pkg::ST_BANK);
  assign idx   = sweep ? c_r : CW'(ch_r);
  assign ch_ok = 32'(ch_r) < 32'(N);
  assign cur   = cur_r[idx];
  assign st    = st_r[idx];
  assign goal  = goal_r[idx];
  assign len   = len_r[idx];
  assign snd   = snd_r[idx];

  // window mapping: num = lo*(1024-I) + hi*I, then (num*16+12)/25
  logic [10:0] isat;
  logic [17:0] num;
  logic [NW-1:0] tgt_dvd;
  logic [42:0]   recip;
  assign isat    = (int_r > 11'd1024) ? 11'd1024 : int_r;
  assign num     = 18'(pct_of(min_r, 32'(idx))) * 18'(11'd1024 - isat) +
                   18'(pct_of(max_r, 32'(idx))) * 18'(isat);
  assign tgt_dvd = NW'({num, 4'b0000}) + NW'(12);
  // dividend stays below 2^21, so the reciprocal product is exact
  assign recip   = 43'(prod_r[20:0]) * 43'(pdr_pkg::PCT_RECIP);

  // elapsed time, negative forced to zero
  logic [31:0] diff, e;
  logic        at_end;
  logic [QB-1:0] absd;
  assign diff   = now_r - beg_r[idx];
  assign e      = diff[31] ? 32'd0 : diff;
  assign at_end = (len == '0) || (e >= 32'(len));
  assign absd   = (goal >= st) ? goal - st : st - goal;

  // shared divider for the interpolation
  logic          div_start, div_done;
  logic [NW-1:0] div_q;

  assign div_start = (state_r == pdr_pkg::ST_TK_MUL);

  pdr_div #(.NW(NW), .DW(RB)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_r),
    .divisor  (len),
    .done     (div_done),
    .quot     (div_q)
  );

  // duty code of the selected channel
  logic [QB-1:0]        capped;
  logic [CDW-1:0]       code_w;
  logic [DUTY_BITS-1:0] code;
  assign capped = (cur > pdr_pkg::DUTY_ONE) ? pdr_pkg::DUTY_ONE : cur;
  assign code_w = CDW'(capped) * CDW'(MAXC) + CDW'(32768);
  assign code   = bank_on_r ? code_w[16 +: DUTY_BITS] : '0;

  logic last_ch, tk_last;
  assign last_ch = (c_r == CW'(N - 1));
  assign tk_last = (em_r >> (32'(c_r) + 1)) == '0;

  assign out_free     = !o_valid_r || out_ch.ready;
  assign in_ch.ready  = (state_r == pdr_pkg::ST_IDLE);
  assign cfg_ch.ready = 1'b1;

  // a word is loaded into the output register this cycle
  assign emit = out_free && (((state_r == pdr_pkg::ST_SI_FIN) && !snd) ||
                             (state_r == pdr_pkg::ST_TK_EMIT) ||
                             (state_r == pdr_pkg::ST_BANK));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pdr_pkg::ST_IDLE: begin
        if (in_ch.valid) state_nxt = pdr_pkg::ST_DISP;
      end
      pdr_pkg::ST_DISP: begin
        case (op_r)
          pdr_pkg::OP_SET: begin
            if (ch_ok && bit_of(en_r, 32'(ch_r)) && int_r != '0) begin
              state_nxt = pdr_pkg::ST_SI_MUL;
            end else begin
              state_nxt = pdr_pkg::ST_IDLE;
            end
          end
          pdr_pkg::OP_ALL, pdr_pkg::OP_DIS: state_nxt = pdr_pkg::ST_BANK;
          pdr_pkg::OP_TICK: state_nxt = pdr_pkg::ST_TK_CHK;
          default: state_nxt = pdr_pkg::ST_IDLE;
        endcase
      end
      pdr_pkg::ST_SI_MUL: state_nxt = pdr_pkg::ST_SI_DIV;
      pdr_pkg::ST_SI_DIV: state_nxt = pdr_pkg::ST_SI_FIN;
      pdr_pkg::ST_SI_FIN: begin
        if (snd || out_free) state_nxt = pdr_pkg::ST_IDLE;
      end
      pdr_pkg::ST_TK_CHK: begin
        if (cur != goal) begin
          state_nxt = at_end ? pdr_pkg::ST_TK_EMIT : pdr_pkg::ST_TK_MUL;
        end else if (last_ch) begin
          state_nxt = pdr_pkg::ST_IDLE;
        end
      end
      pdr_pkg::ST_TK_MUL: state_nxt = pdr_pkg::ST_TK_DIV;
      pdr_pkg::ST_TK_DIV: begin
        if (div_done) state_nxt = pdr_pkg::ST_TK_EMIT;
      end
      pdr_pkg::ST_TK_EMIT: begin
        if (out_free) state_nxt = last_ch ? pdr_pkg::ST_IDLE : pdr_pkg::ST_TK_CHK;
      end
      pdr_pkg::ST_BANK: begin
        if (out_free && last_ch) state_nxt = pdr_pkg::ST_IDLE;
      end
      default: state_nxt = pdr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= pdr_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  // datapath and channel state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r     <= '0;
      max_r     <= pdr_pkg::MAX_RESET[27:0];
      up_r      <= '0;
      dn_r      <= '0;
      en_r      <= '0;
      rev_r     <= '0;
      alt_r     <= '0;
      snd_r     <= '0;
      par_r     <= '0;
      dir_r     <= '0;
      bank_on_r <= 1'b0;
      o_valid_r <= 1'b0;
      c_r       <= '0;
      em_r      <= '0;
      for (int i = 0; i < N; i++) begin
        cur_r[i]  <= '0;
        st_r[i]   <= '0;
        goal_r[i] <= '0;
        beg_r[i]  <= '0;
        len_r[i]  <= '0;
      end
    end else begin
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          pdr_pkg::CFG_MIN:  min_r <= cfg_ch.data[27:0];
          pdr_pkg::CFG_MAX:  max_r <= cfg_ch.data[27:0];
          pdr_pkg::CFG_UP:   up_r  <= cfg_ch.data;
          pdr_pkg::CFG_DOWN: dn_r  <= cfg_ch.data;
          pdr_pkg::CFG_EN:   en_r  <= cfg_ch.data[3:0];
          pdr_pkg::CFG_REV:  rev_r <= cfg_ch.data[3:0];
          pdr_pkg::CFG_ALT:  alt_r <= cfg_ch.data[3:0];
          default: ;
        endcase
      end

      if (emit)              o_valid_r <= 1'b1;
      else if (out_ch.ready) o_valid_r <= 1'b0;

      case (state_r)
        pdr_pkg::ST_IDLE: begin
          if (in_ch.valid) begin
            op_r  <= in_ch.operation;
            ch_r  <= in_ch.channel;
            int_r <= in_ch.intensity;
            now_r <= in_ch.now_ms;
          end
        end
        pdr_pkg::ST_DISP: begin
          c_r <= '0;
          for (int i = 0; i < N; i++) em_r[i] <= cur_r[i] != goal_r[i];
          if (op_r == pdr_pkg::OP_EN)  bank_on_r <= 1'b1;
          if (op_r == pdr_pkg::OP_DIS) bank_on_r <= 1'b0;
          // stop, or set intensity at zero: spin down unless silent
          if (ch_ok && (op_r == pdr_pkg::OP_STOP ||
              (op_r == pdr_pkg::OP_SET && int_r == '0 && bit_of(en_r, 32'(ch_r))))) begin
            if (snd || cur != '0) begin
              st_r[idx]   <= cur;
              goal_r[idx] <= '0;
              len_r[idx]  <= ramp_of(dn_r, 32'(idx));
              beg_r[idx]  <= now_r;
            end
          end
        end
        pdr_pkg::ST_SI_MUL: begin
          prod_r <= tgt_dvd;
        end
        pdr_pkg::ST_SI_DIV: begin
          tgt_r <= recip[pdr_pkg::PCT_SHIFT +: QB];
        end
        pdr_pkg::ST_SI_FIN: begin
          if (snd || out_free) begin
            if (!snd) begin
              // fresh note: pick direction, flip parity when alternating
              dir_r[idx] <= bit_of(rev_r, 32'(idx)) ^ (bit_of(alt_r, 32'(idx)) & par_r[idx]);
              par_r[idx] <= par_r[idx] ^ bit_of(alt_r, 32'(idx));
              snd_r[idx] <= 1'b1;
              o_ch_r     <= ch_r;
              o_code_r   <= '0;
              o_dw_r     <= 1'b0;
              o_dir_r    <= bit_of(rev_r, 32'(idx)) ^
                            (bit_of(alt_r, 32'(idx)) & par_r[idx]);
              o_dirw_r   <= 1'b1;
              o_last_r   <= 1'b1;
            end
            st_r[idx]   <= cur;
            goal_r[idx] <= tgt_r;
            len_r[idx]  <= ramp_of(up_r, 32'(idx));
            beg_r[idx]  <= now_r;
          end
        end
        pdr_pkg::ST_TK_CHK: begin
          if (cur == goal) begin
            if (goal == '0) snd_r[idx] <= 1'b0;
            c_r <= c_r + 1'b1;
          end else if (at_end) begin
            cur_r[idx] <= goal;
          end else begin
            prod_r <= NW'(absd) * NW'(e[RB-1:0]);
          end
        end
        pdr_pkg::ST_TK_DIV: begin
          if (div_done) begin
            cur_r[idx] <= (goal >= st) ? QB'(st + div_q[QB-1:0])
                                       : QB'(st - div_q[QB-1:0]);
          end
        end
        pdr_pkg::ST_TK_EMIT: begin
          if (out_free) begin
            o_ch_r    <= 2'(c_r);
            o_code_r  <= code;
            o_dw_r    <= 1'b1;
            o_dir_r   <= dir_r[idx];
            o_dirw_r  <= 1'b0;
            o_last_r  <= tk_last;
            if (cur == goal && goal == '0) snd_r[idx] <= 1'b0;
            c_r <= c_r + 1'b1;
          end
        end
        pdr_pkg::ST_BANK: begin
          if (out_free) begin
            cur_r[idx]  <= '0;
            goal_r[idx] <= '0;
            if (op_r == pdr_pkg::OP_ALL) st_r[idx] <= '0;
            snd_r[idx]  <= 1'b0;
            o_ch_r      <= 2'(c_r);
            o_code_r    <= '0;
            o_dw_r      <= 1'b1;
            o_dir_r     <= dir_r[idx];
            o_dirw_r    <= 1'b0;
            o_last_r    <= last_ch;
            c_r         <= c_r + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_ch.valid             = o_valid_r;
  assign out_ch.out_channel       = o_ch_r;
  assign out_ch.duty_code         = o_code_r;
  assign out_ch.duty_written      = o_dw_r;
  assign out_ch.direction         = o_dir_r;
  assign out_ch.direction_written = o_dirw_r;
  assign out_ch.last              = o_last_r;
endmodule

@@ tb/pdr_duty_board.sv @@
`timescale 1ns / 100ps

// Result checker for the duty ramper: predicted words are queued per accepted
// command, then popped against each word coming off the result channel.
package pdr_duty_board;
  typedef struct packed {
    logic [1:0] chan;
    logic [9:0] code;
    logic       dw;
    logic       dir;
    logic       dirw;
    logic       lst;
  } duty_word_t;

  class duty_board;
    duty_word_t pending[$];

    function void note_word(duty_word_t w);
      pending.push_back(w);
    endfunction

    function bit check_word(duty_word_t got, output duty_word_t want);
      if (pending.size() == 0) begin
        want = '0;
        return 0;
      end
      want = pending.pop_front();
      return got == want;
    endfunction
  endclass
endpackage

@@ tb/tb.sv @@
`timescale 1ns / 100ps

module tb;
  localparam int NCH = 4;
  localparam int IDLE_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #2 clk = ~clk;

  pdr_in_if  in_ch();
  pdr_out_if #(.DUTY_BITS(10)) out_ch();
  pdr_cfg_if cfg_ch();

  multi_channel_pwm_duty_ramper_unit i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  pdr_duty_board::duty_board board = new();

  // predictor copy of registers and channel state
  logic [27:0] r_min, r_max;
  logic [47:0] r_up, r_down;
  logic [3:0]  r_en, r_rev, r_alt;
  logic [16:0] p_cur[NCH], p_start[NCH], p_goal[NCH];
  logic [31:0] p_begin[NCH];
  logic [11:0] p_len[NCH];
  logic        p_snd[NCH], p_par[NCH], p_dir[NCH];
  logic        p_bank;

  int send_idle_pct, recv_idle_pct;
  int idle_cycles = 0;
  int mismatches = 0;

  task automatic report(string what);
    $display("mismatch: %s", what);
    mismatches++;
  endtask

  function automatic logic [9:0] code_of(logic [16:0] d);
    logic [26:0] t;
    if (!p_bank) return 10'd0;
    if (d > pdr_pkg::DUTY_ONE) d = pdr_pkg::DUTY_ONE;
    t = 27'(d) * 27'd1023 + 27'd32768;
    return t[25:16];
  endfunction

  function automatic void push(int c, logic [9:0] code, logic dw, logic dir, logic dirw);
    pdr_duty_board::duty_word_t w;
    w.chan = c[1:0]; w.code = code; w.dw = dw; w.dir = dir; w.dirw = dirw; w.lst = 1'b0;
    board.note_word(w);
  endfunction

  function automatic void stop_chan(int c, logic [31:0] now);
    if (!p_snd[c] && p_cur[c] == '0) return;
    p_start[c] = p_cur[c]; p_goal[c] = '0;
    p_len[c] = r_down[c*12 +: 12]; p_begin[c] = now;
  endfunction

  // apply one accepted command to the predictor, queueing its words
  function automatic void predict_cmd(logic [2:0] op, logic [1:0] ch, logic [10:0] inten,
                                      logic [31:0] now);
    int base, c;
    logic [31:0] lo, hi, num, tgt, diff, e;
    logic [16:0] cur;
    logic [63:0] prod;
    base = board.pending.size();
    case (op)
      pdr_pkg::OP_SET: begin
        if (r_en[ch]) begin
          if (inten == '0) stop_chan(int'(ch), now);
          else begin
            if (inten > 11'd1024) inten = 11'd1024;
            lo = 32'(r_min[ch*7 +: 7]); hi = 32'(r_max[ch*7 +: 7]);
            num = lo * (32'd1024 - 32'(inten)) + hi * 32'(inten);
            tgt = (num * 32'd16 + 32'd12) / 32'd25;
            if (!p_snd[ch]) begin
              p_dir[ch] = r_rev[ch] ^ (r_alt[ch] & p_par[ch]);
              if (r_alt[ch]) p_par[ch] = ~p_par[ch];
              p_snd[ch] = 1'b1;
              push(int'(ch), 10'd0, 1'b0, p_dir[ch], 1'b1);
            end
            p_start[ch] = p_cur[ch]; p_goal[ch] = tgt[16:0];
            p_len[ch] = r_up[ch*12 +: 12]; p_begin[ch] = now;
          end
        end
      end
      pdr_pkg::OP_STOP: stop_chan(int'(ch), now);
      pdr_pkg::OP_ALL, pdr_pkg::OP_DIS: begin
        if (op == pdr_pkg::OP_DIS) p_bank = 1'b0;
        for (c = 0; c < NCH; c++) begin
          p_cur[c] = '0; p_goal[c] = '0; p_snd[c] = 1'b0;
          if (op == pdr_pkg::OP_ALL) p_start[c] = '0;
          push(c, code_of(17'd0), 1'b1, p_dir[c], 1'b0);
        end
      end
      pdr_pkg::OP_TICK: begin
        for (c = 0; c < NCH; c++) begin
          if (p_cur[c] == p_goal[c]) begin
            if (p_goal[c] == '0) p_snd[c] = 1'b0;
          end else begin
            cur = p_goal[c];
            if (p_len[c] != '0) begin
              diff = now - p_begin[c];
              e = diff[31] ? 32'd0 : diff;
              if (e < 32'(p_len[c])) begin
                if (p_goal[c] >= p_start[c]) begin
                  prod = 64'(p_goal[c] - p_start[c]) * 64'(e) / 64'(p_len[c]);
                  cur = p_start[c] + prod[16:0];
                end else begin
                  prod = 64'(p_start[c] - p_goal[c]) * 64'(e) / 64'(p_len[c]);
                  cur = p_start[c] - prod[16:0];
                end
              end
            end
            p_cur[c] = cur;
            push(c, code_of(cur), 1'b1, p_dir[c], 1'b0);
            if (cur == p_goal[c] && p_goal[c] == '0) p_snd[c] = 1'b0;
          end
        end
      end
      pdr_pkg::OP_EN: p_bank = 1'b1;
      default: ;
    endcase
    if (board.pending.size() > base) board.pending[$].lst = 1'b1;
  endfunction

  // result side: random stall, check each accepted word
  always @(posedge clk) begin
    pdr_duty_board::duty_word_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = {out_ch.out_channel, out_ch.duty_code, out_ch.duty_written,
             out_ch.direction, out_ch.direction_written, out_ch.last};
      if (!board.check_word(got, want))
        report($sformatf("got %h want %h", got, want));
    end
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // watchdog: cycles with no handshake on any channel
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // valid is left high after acceptance; the next driver decides
  task automatic send_cmd(logic [2:0] op, logic [1:0] ch, logic [10:0] inten,
                          logic [31:0] now);
    cfg_ch.valid <= 1'b0;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1; in_ch.operation <= op; in_ch.channel <= ch;
    in_ch.intensity <= inten; in_ch.now_ms <= now;
    do @(posedge clk); while (!in_ch.ready);
    predict_cmd(op, ch, inten, now);
  endtask

  task automatic drain();
    int n;
    n = 0;
    in_ch.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    // let a command with no words finish before touching registers
    while (n < 200) begin @(posedge clk); n++; end
  endtask

  task automatic write_reg(logic [2:0] idx, logic [47:0] val);
    cfg_ch.valid <= 1'b1; cfg_ch.index <= idx; cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      pdr_pkg::CFG_MIN:  r_min  = val[27:0];
      pdr_pkg::CFG_MAX:  r_max  = val[27:0];
      pdr_pkg::CFG_UP:   r_up   = val;
      pdr_pkg::CFG_DOWN: r_down = val;
      pdr_pkg::CFG_EN:   r_en   = val[3:0];
      pdr_pkg::CFG_REV:  r_rev  = val[3:0];
      pdr_pkg::CFG_ALT:  r_alt  = val[3:0];
      default: ;
    endcase
  endtask

  // short ramps keep interpolation visible at ms steps
  task automatic random_setup(bit extreme);
    write_reg(pdr_pkg::CFG_MIN, extreme ? 48'hFFFFFFF : 48'({$urandom} & 32'hFFFFFFF));
    write_reg(pdr_pkg::CFG_MAX, extreme ? 48'h0 : 48'({$urandom} & 32'hFFFFFFF));
    write_reg(pdr_pkg::CFG_UP, extreme ? 48'hFFFFFFFFFFFF :
              48'({$urandom, $urandom} & 64'h03F03F03F03F));
    write_reg(pdr_pkg::CFG_DOWN, extreme ? 48'h0 :
              48'({$urandom, $urandom} & 64'h07F07F07F07F));
    write_reg(pdr_pkg::CFG_EN, 48'($urandom_range(15) | 1));
    write_reg(pdr_pkg::CFG_REV, 48'($urandom_range(15)));
    write_reg(pdr_pkg::CFG_ALT, 48'($urandom_range(15)));
  endtask

  task automatic random_phase(int count, int sidle, int ridle);
    logic [31:0] now;
    logic [2:0] op;
    int k, pick;
    send_idle_pct = sidle; recv_idle_pct = ridle;
    now = $urandom;
    for (k = 0; k < count; k++) begin
      pick = $urandom_range(99);
      // mostly notes and ticks so ramps run through their middles
      if (pick < 35) op = pdr_pkg::OP_SET;
      else if (pick < 70) op = pdr_pkg::OP_TICK;
      else if (pick < 82) op = pdr_pkg::OP_STOP;
      else if (pick < 88) op = pdr_pkg::OP_EN;
      else if (pick < 92) op = pdr_pkg::OP_ALL;
      else if (pick < 96) op = pdr_pkg::OP_DIS;
      else op = 3'($urandom_range(7));
      now = now + $urandom_range(40);
      if ($urandom_range(49) == 0) now = now - $urandom_range(100);
      send_cmd(op, 2'($urandom_range(3)),
               ($urandom_range(9) == 0) ? 11'($urandom_range(2047))
                                        : 11'($urandom_range(1024)), now);
    end
  endtask

  initial begin
    int c;
    send_idle_pct = 0; recv_idle_pct = 0;
    in_ch.valid = 1'b0; in_ch.operation = '0; in_ch.channel = '0;
    in_ch.intensity = '0; in_ch.now_ms = '0;
    cfg_ch.valid = 1'b0; cfg_ch.index = '0; cfg_ch.data = '0;
    r_min = '0; r_max = pdr_pkg::MAX_RESET[27:0]; r_up = '0; r_down = '0;
    r_en = '0; r_rev = '0; r_alt = '0; p_bank = 1'b0;
    for (c = 0; c < NCH; c++) begin
      p_cur[c] = '0; p_start[c] = '0; p_goal[c] = '0; p_begin[c] = '0; p_len[c] = '0;
      p_snd[c] = 1'b0; p_par[c] = 1'b0; p_dir[c] = 1'b0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset registers, disabled channel, then full windows
    send_cmd(pdr_pkg::OP_SET, 2'd0, 11'd512, 32'd0);
    send_cmd(pdr_pkg::OP_TICK, 2'd0, 11'd0, 32'd5);
    drain();
    write_reg(pdr_pkg::CFG_EN, 48'hF);
    write_reg(pdr_pkg::CFG_UP, 48'h00A_064_000_FFF);
    write_reg(pdr_pkg::CFG_DOWN, 48'h000_005_FFF_010);
    write_reg(pdr_pkg::CFG_ALT, 48'b0101);
    write_reg(pdr_pkg::CFG_REV, 48'b0011);
    write_reg(pdr_pkg::CFG_MIN, 48'({7'd127, 7'd0, 7'd50, 7'd0}));
    write_reg(pdr_pkg::CFG_MAX, 48'({7'd0, 7'd127, 7'd100, 7'd100}));
    send_cmd(pdr_pkg::OP_EN, 2'd0, 11'd0, 32'd0);
    send_cmd(pdr_pkg::OP_SET, 2'd0, 11'd1024, 32'd100);
    send_cmd(pdr_pkg::OP_SET, 2'd1, 11'd2047, 32'd100);
    send_cmd(pdr_pkg::OP_SET, 2'd2, 11'd1, 32'd100);
    send_cmd(pdr_pkg::OP_SET, 2'd3, 11'd700, 32'hFFFF_FFF0);
    send_cmd(pdr_pkg::OP_TICK, 2'd0, 11'd0, 32'd50);
    send_cmd(pdr_pkg::OP_SET, 2'd0, 11'd300, 32'd60);
    send_cmd(pdr_pkg::OP_TICK, 2'd0, 11'd0, 32'd99);
    send_cmd(pdr_pkg::OP_TICK, 2'd0, 11'd0, 32'd5000);
    send_cmd(pdr_pkg::OP_STOP, 2'd0, 11'd0, 32'd5000);
    send_cmd(pdr_pkg::OP_SET, 2'd1, 11'd0, 32'd5000);
    send_cmd(pdr_pkg::OP_TICK, 2'd0, 11'd0, 32'd4990);
    send_cmd(pdr_pkg::OP_TICK, 2'd0, 11'd0, 32'd9000);
    send_cmd(pdr_pkg::OP_TICK, 2'd0, 11'd0, 32'd9001);
    send_cmd(pdr_pkg::OP_STOP, 2'd2, 11'd0, 32'd9002);
    send_cmd(3'd6, 2'd1, 11'd5, 32'd1);
    send_cmd(3'd7, 2'd2, 11'd5, 32'd1);
    send_cmd(pdr_pkg::OP_ALL, 2'd0, 11'd0, 32'd1);
    send_cmd(pdr_pkg::OP_SET, 2'd2, 11'd512, 32'd1);
    send_cmd(pdr_pkg::OP_DIS, 2'd0, 11'd0, 32'd2);
    send_cmd(pdr_pkg::OP_SET, 2'd0, 11'd1024, 32'd3);
    send_cmd(pdr_pkg::OP_TICK, 2'd0, 11'd0, 32'd4);

    // the sender pauses here until every word has drained
    drain();
    random_setup(1'b1);
    random_phase(100, 9, 79);
    drain();
    random_setup(1'b0);
    random_phase(100, 79, 9);
    drain();
    random_setup(1'b0);
    random_phase(86, 0, 0);
    drain();

    if (mismatches == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule

@@ sim.f @@
sv/pdr_pkg.sv
sv/pdr_if.sv
sv/pdr_div.sv
sv/multi_channel_pwm_duty_ramper_unit.sv
tb/pdr_duty_board.sv
tb/tb.sv
